@@ hw/rtl/ptt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

	// Field widths of the channels
	localparam int unsigned POS_W  = 12;
	localparam int unsigned DUTY_W = 11;
	localparam int unsigned ERR_W  = 13;
	localparam int unsigned ANG_W  = 24;

	// Shared multiplier operand and product widths
	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 24;
	localparam int unsigned PROD_W  = 44;

	// Angle limits, Q8.16 degrees
	localparam logic [ANG_W-1:0] ANGLE_RESET = 24'd5898240;
	localparam logic [ANG_W-1:0] PAN_MIN     = 24'd655360;
	localparam logic [ANG_W-1:0] PAN_MAX     = 24'd11141120;
	localparam logic [ANG_W-1:0] TILT_MIN    = 24'd1966080;
	localparam logic [ANG_W-1:0] TILT_MAX    = 24'd9830400;

	// Step factor 3277/65536 and duty offset (45 degrees in Q8.16 after /2000)
	localparam logic [MUL_B_W-1:0] STEP_NUM    = 24'd3277;
	localparam logic [ANG_W-1:0]   DUTY_OFFSET = 24'd2949120;
	// ceil(2^29 / 225), exact for dividends below 2^21
	localparam logic [MUL_B_W-1:0] RECIP_225   = 24'd2386093;

	// Configuration register indexes and reset values
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_PROP_GAIN    = 2'd2;
	localparam logic [1:0] CFG_DERIV_GAIN   = 2'd3;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;
	localparam logic [15:0] KP_RESET     = 16'd1966;
	localparam logic [15:0] KD_RESET     = 16'd655;

	typedef struct packed {
		logic [POS_W-1:0] target_x;
		logic [POS_W-1:0] target_y;
		logic             target_lost;
	} ptt_in_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_pan;
		logic [DUTY_W-1:0] duty_tilt;
	} ptt_out_t;

	// Operand selection of the shared multiplier
	typedef enum logic [2:0] {
		MUL_KP    = 3'd0,
		MUL_KD    = 3'd1,
		MUL_STEP  = 3'd2,
		MUL_DUTY  = 3'd3,
		MUL_RECIP = 3'd4
	} ptt_mul_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic         load_in;
		logic         mul_en;
		ptt_mul_sel_t mul_sel;
		logic         acc_load;
		logic         acc_add;
		logic         ang_upd;
		logic         duty_wr;
		logic         axis;
		logic         out_load;
	} ptt_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/pan_tilt_pd_servo_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake              Word
// in       in_valid / in_ready    in_data  (target_x, target_y, target_lost)
// out      out_valid / out_ready  out_data (duty_pan, duty_tilt)
// cfg      cfg_we                 cfg_index, cfg_data
//
// A tracked frame runs the pan axis and then the tilt axis through the single shared
// multiplier in states KP to QUOT, loads the output register in DONE and returns to idle.
// A frame with target_lost set is taken while idle and changes nothing.
// Reset sets the angles to 90 degrees, the errors to zero and the registers to defaults.
// A result waiting in the output register holds the sequencer in its last step only.
module pan_tilt_pd_servo_tracker #(
	parameter int unsigned DUTY_BITS = 14,
	parameter int unsigned POS_BITS  = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ptt_pkg::ptt_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ptt_pkg::ptt_out_t     out_data
);
	import ptt_pkg::*;

	ptt_cmd_t cmd;

	ptt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.target_lost (in_data.target_lost),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd         (cmd)
	);

	ptt_datapath #(
		.DUTY_BITS (DUTY_BITS),
		.POS_BITS  (POS_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

@@ hw/rtl/ptt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ptt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          target_lost,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ptt_pkg::ptt_cmd_t  cmd
);
	import ptt_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_KP    = 10'b00_0000_0010,
		S_KD    = 10'b00_0000_0100,
		S_SUM   = 10'b00_0000_1000,
		S_STEP  = 10'b00_0001_0000,
		S_ANG   = 10'b00_0010_0000,
		S_DUTY  = 10'b00_0100_0000,
		S_RECIP = 10'b00_1000_0000,
		S_QUOT  = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_nx;
	logic   axis_q, axis_nx;
	logic   out_valid_q, out_valid_nx;
	logic   take;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign take      = in_valid && in_ready && !target_lost;

	// Sequencer: pan axis then tilt axis through the shared multiplier
	always_comb begin
		state_nx     = state_q;
		axis_nx      = axis_q;
		out_valid_nx = out_valid_q && !out_ready;
		cmd          = '0;
		cmd.mul_sel  = MUL_KP;
		cmd.axis     = axis_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd.load_in = 1'b1;
					axis_nx     = 1'b0;
					state_nx    = S_KP;
				end
			end
			S_KP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_KP;
				state_nx    = S_KD;
			end
			S_KD: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_KD;
				cmd.acc_load = 1'b1;
				state_nx     = S_SUM;
			end
			S_SUM: begin
				cmd.acc_add = 1'b1;
				state_nx    = S_STEP;
			end
			S_STEP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_STEP;
				state_nx    = S_ANG;
			end
			S_ANG: begin
				cmd.ang_upd = 1'b1;
				state_nx    = S_DUTY;
			end
			S_DUTY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DUTY;
				state_nx    = S_RECIP;
			end
			S_RECIP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RECIP;
				state_nx    = S_QUOT;
			end
			S_QUOT: begin
				cmd.duty_wr = 1'b1;
				if (axis_q) begin
					state_nx = S_DONE;
				end else begin
					axis_nx  = 1'b1;
					state_nx = S_KP;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_nx = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			axis_q      <= axis_nx;
			out_valid_q <= out_valid_nx;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ptt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ptt_datapath #(
	parameter int unsigned DUTY_BITS = 14,
	parameter int unsigned POS_BITS  = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire ptt_pkg::ptt_in_t  in_data,
	input  wire ptt_pkg::ptt_cmd_t cmd,
	output ptt_pkg::ptt_out_t      out_data
);
	import ptt_pkg::*;

	localparam logic [POS_W-1:0] POS_MASK =
		(POS_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << POS_BITS) - 1);
	localparam logic [MUL_B_W-1:0] DUTY_FULL = MUL_B_W'((1 << DUTY_BITS) - 1);

	// Configuration registers
	logic [11:0] width_q, height_q;
	logic [15:0] kp_q, kd_q;

	// Servo state
	logic [ANG_W-1:0]        pan_q, tilt_q;
	logic signed [ERR_W-1:0] lex_q, ley_q;

	// Working registers
	logic signed [ERR_W-1:0]   ex_q, ey_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [MUL_A_W-1:0] acc_q;
	logic [DUTY_W-1:0]         duty_pan_q;
	ptt_out_t                  out_q;

	logic [POS_W-1:0]          tx, ty;
	logic signed [ERR_W-1:0]   ex_nx, ey_nx, err, prev;
	logic signed [ERR_W:0]     diff;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
	logic [ANG_W-1:0]          ang, duty_arg;
	logic signed [PROD_W-1:0]  rnd;
	logic signed [27:0]        delta;
	logic signed [29:0]        ang_ext, delta_ext, ang_sum, lo, hi, ang_clamped;

	// Pixel error from the image centre
	assign tx    = in_data.target_x & POS_MASK;
	assign ty    = in_data.target_y & POS_MASK;
	assign ex_nx = $signed({1'b0, tx}) - $signed({2'b00, width_q[11:1]});
	assign ey_nx = $signed({1'b0, ty}) - $signed({2'b00, height_q[11:1]});

	assign err      = cmd.axis ? ey_q : ex_q;
	assign prev     = cmd.axis ? ley_q : lex_q;
	assign diff     = {err[ERR_W-1], err} - {prev[ERR_W-1], prev};
	assign ang      = cmd.axis ? tilt_q : pan_q;
	assign duty_arg = ang + DUTY_OFFSET;

	// Shared multiplier operand selection
	always_comb begin
		case (cmd.mul_sel)
			MUL_KP: begin
				mul_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
				mul_b = $signed({8'd0, kp_q});
			end
			MUL_KD: begin
				mul_a = {{(MUL_A_W-ERR_W-1){diff[ERR_W]}}, diff};
				mul_b = $signed({8'd0, kd_q});
			end
			MUL_STEP: begin
				mul_a = acc_q;
				mul_b = $signed(STEP_NUM);
			end
			MUL_DUTY: begin
				mul_a = $signed({8'd0, duty_arg});
				mul_b = $signed(DUTY_FULL);
			end
			MUL_RECIP: begin
				// divide by 8 and then by 225, the 2^16 having gone with the shift
				mul_a = $signed({11'd0, prod_q[39:19]});
				mul_b = $signed(RECIP_225);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Step rounding to nearest, ties upward, then clamp to the axis limits
	assign rnd       = prod_q + 44'sd32768;
	assign delta     = rnd[43:16];
	assign ang_ext   = $signed({6'd0, ang});
	assign delta_ext = {{2{delta[27]}}, delta};
	assign ang_sum   = cmd.axis ? (ang_ext + delta_ext) : (ang_ext - delta_ext);
	assign lo        = $signed({6'd0, cmd.axis ? TILT_MIN : PAN_MIN});
	assign hi        = $signed({6'd0, cmd.axis ? TILT_MAX : PAN_MAX});

	always_comb begin
		if (ang_sum < lo) begin
			ang_clamped = lo;
		end else if (ang_sum > hi) begin
			ang_clamped = hi;
		end else begin
			ang_clamped = ang_sum;
		end
	end

	// Configuration and servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			kp_q     <= KP_RESET;
			kd_q     <= KD_RESET;
			pan_q    <= ANGLE_RESET;
			tilt_q   <= ANGLE_RESET;
			lex_q    <= '0;
			ley_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q  <= cfg_data[11:0];
					CFG_IMAGE_HEIGHT: height_q <= cfg_data[11:0];
					CFG_PROP_GAIN:    kp_q     <= cfg_data;
					CFG_DERIV_GAIN:   kd_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.ang_upd) begin
				if (cmd.axis) begin
					tilt_q <= ang_clamped[ANG_W-1:0];
					ley_q  <= err;
				end else begin
					pan_q <= ang_clamped[ANG_W-1:0];
					lex_q <= err;
				end
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ex_q <= ex_nx;
			ey_q <= ey_nx;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p[PROD_W-1:0];
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q[MUL_A_W-1:0];
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q[MUL_A_W-1:0];
		end
		if (cmd.duty_wr && !cmd.axis) begin
			duty_pan_q <= prod_q[39:29];
		end
		if (cmd.out_load) begin
			out_q.duty_pan  <= duty_pan_q;
			out_q.duty_tilt <= prod_q[39:29];
		end
	end

	// tilt quotient is still in prod_q when the word is loaded
	assign out_data = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/ptt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ptt_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire ptt_pkg::ptt_in_t  in_data,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire ptt_pkg::ptt_out_t out_data
);
	import ptt_pkg::*;

	// A waiting word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// A tracked frame occupies the sequencer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.target_lost |=> !in_ready)
		else $error("input taken again during a frame");

	// A lost frame leaves the block ready
	a_lost_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.target_lost |=> in_ready)
		else $error("lost frame started work");

	// A new word only appears at the end of a frame
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a frame in progress");

endmodule

bind pan_tilt_pd_servo_tracker ptt_checker u_ptt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

@@ tb/tracker_checker.sv @@
`timescale 1ns / 1ps
// Watches the frame, result and register ports, predicts the servo duties of
// every tracked frame and compares each result word with the oldest prediction.
module tracker_checker
	import ptt_pkg::*;
#(
	parameter int unsigned DUTY_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  ptt_in_t     in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  ptt_out_t    out_data,
	output int unsigned mismatches,
	output int unsigned duties_due
);

	localparam longint ONE_DEG    = 65536;
	localparam longint STEP_GAIN  = 3277;
	localparam longint DUTY_BASE  = 64'sd5898240000;   // 45 degrees times 2000 offset in Q16
	localparam longint DUTY_DIV   = 64'sd235929600000; // 3600000 * 65536
	localparam longint DUTY_FULL  = (64'sd1 <<< DUTY_BITS) - 1;
	localparam longint PAN_LO     = 10 * ONE_DEG;
	localparam longint PAN_HI     = 170 * ONE_DEG;
	localparam longint TILT_LO    = 30 * ONE_DEG;
	localparam longint TILT_HI    = 150 * ONE_DEG;
	localparam longint HOME_ANGLE = 90 * ONE_DEG;

	// Mirrored registers
	logic [11:0] img_w;
	logic [11:0] img_h;
	logic [15:0] kp;
	logic [15:0] kd;

	// Mirrored tracker state
	longint pan_q16;
	longint tilt_q16;
	int     prev_ex;
	int     prev_ey;

	ptt_out_t duty_queue[$];

	// PD term scaled by the step factor, rounded to nearest (ties upward)
	function automatic longint pd_step(int err, int prev, logic [15:0] gp, logic [15:0] gd);
		longint term;
		term = longint'(gp) * err + longint'(gd) * (err - prev);
		return (term * STEP_GAIN + 32768) >>> 16;
	endfunction

	function automatic longint clamp_angle(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Pulse 0.5..2.5 ms of 20 ms, low 11 bits kept
	function automatic logic [DUTY_W-1:0] servo_duty(longint angle);
		longint a;
		a = clamp_angle(angle, 0, 180 * ONE_DEG);
		return DUTY_W'(((DUTY_BASE + 2000 * a) * DUTY_FULL) / DUTY_DIV);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ptt_out_t want;
		int       ex;
		int       ey;
		if (!arst_n) begin
			img_w      = WIDTH_RESET;
			img_h      = HEIGHT_RESET;
			kp         = KP_RESET;
			kd         = KD_RESET;
			pan_q16    = HOME_ANGLE;
			tilt_q16   = HOME_ANGLE;
			prev_ex    = 0;
			prev_ey    = 0;
			mismatches = 0;
			duty_queue.delete();
			duties_due = 0;
		end else begin
			// result word against oldest prediction
			if (out_valid && out_ready) begin
				if (duty_queue.size() == 0) begin
					$display("%0t: unexpected word duty_pan %0d duty_tilt %0d", $time,
						out_data.duty_pan, out_data.duty_tilt);
					mismatches++;
				end else begin
					want = duty_queue.pop_front();
					if (out_data.duty_pan !== want.duty_pan) begin
						$display("%0t: duty_pan expected %0d, got %0d", $time,
							want.duty_pan, out_data.duty_pan);
						mismatches++;
					end
					if (out_data.duty_tilt !== want.duty_tilt) begin
						$display("%0t: duty_tilt expected %0d, got %0d", $time,
							want.duty_tilt, out_data.duty_tilt);
						mismatches++;
					end
				end
			end

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: begin
						img_w = cfg_data[11:0];
					end
					CFG_IMAGE_HEIGHT: begin
						img_h = cfg_data[11:0];
					end
					CFG_PROP_GAIN: begin
						kp = cfg_data;
					end
					CFG_DERIV_GAIN: begin
						kd = cfg_data;
					end
					default: begin
					end
				endcase
			end

			// frame word: lost target changes nothing
			if (in_valid && in_ready && !in_data.target_lost) begin
				ex       = int'(in_data.target_x) - int'(img_w >> 1);
				ey       = int'(in_data.target_y) - int'(img_h >> 1);
				pan_q16  = clamp_angle(pan_q16 - pd_step(ex, prev_ex, kp, kd), PAN_LO, PAN_HI);
				tilt_q16 = clamp_angle(tilt_q16 + pd_step(ey, prev_ey, kp, kd), TILT_LO, TILT_HI);
				prev_ex  = ex;
				prev_ey  = ey;
				want.duty_pan  = servo_duty(pan_q16);
				want.duty_tilt = servo_duty(tilt_q16);
				duty_queue.push_back(want);
			end
			duties_due = duty_queue.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Frame stimulus, random back-pressure and the verdict for the servo tracker.
module testbench;
	import ptt_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE       = 40;
	localparam int PHASES       = 7;
	localparam int PHASE_FRAMES = 56;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	ptt_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	ptt_out_t    out_data;

	int unsigned mismatches;
	int unsigned duties_due;

	// no idling on either side while set
	bit          burst;
	logic [11:0] cur_w;
	logic [11:0] cur_h;

	pan_tilt_pd_servo_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	tracker_checker duty_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.duties_due (duties_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Send one frame word; valid is left high for a back-to-back follower
	task automatic send_frame(logic [11:0] x, logic [11:0] y, logic lost);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid            = 1'b1;
		in_data.target_x    = x;
		in_data.target_y    = y;
		in_data.target_lost = lost;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drain results, then hold the input idle before the next step
	task automatic settle();
		in_valid = 1'b0;
		wait (duties_due == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write all four registers on consecutive edges
	task automatic write_regs(logic [15:0] w, logic [15:0] h, logic [15:0] gp, logic [15:0] gd);
		cfg_we    = 1'b1;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data  = w;
		@(negedge clk);
		cfg_index = CFG_IMAGE_HEIGHT;
		cfg_data  = h;
		@(negedge clk);
		cfg_index = CFG_PROP_GAIN;
		cfg_data  = gp;
		@(negedge clk);
		cfg_index = CFG_DERIV_GAIN;
		cfg_data  = gd;
		@(negedge clk);
		cfg_we    = 1'b0;
		cur_w     = w[11:0];
		cur_h     = h[11:0];
	endtask

	// Position near the centre most of the time, anywhere otherwise
	function automatic logic [11:0] pick_pos(logic [11:0] size);
		int v;
		if ($urandom_range(0, 3) == 0)
			return 12'($urandom_range(0, 4095));
		v = int'(size >> 1) + int'($urandom_range(0, 240)) - 120;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	// Result side back-pressure
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no word moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int          tracked;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] gp;
		logic [15:0] gd;
		logic        lost;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		burst     = 1'b0;
		cur_w     = WIDTH_RESET;
		cur_h     = HEIGHT_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset registers, centre, field extremes, lost frames
		send_frame(12'd320, 12'd240, 1'b0);
		send_frame(12'd0, 12'd0, 1'b0);
		send_frame(12'd4095, 12'd4095, 1'b0);
		send_frame(12'd4095, 12'd0, 1'b1);
		send_frame(12'd0, 12'd4095, 1'b1);
		send_frame(12'd4095, 12'd0, 1'b0);
		send_frame(12'd0, 12'd4095, 1'b0);
		send_frame(12'd320, 12'd240, 1'b0);
		settle();

		// full gains: drive both axes into their limits each way
		write_regs(16'd640, 16'd480, 16'hFFFF, 16'hFFFF);
		repeat (3) send_frame(12'd4095, 12'd4095, 1'b0);
		repeat (3) send_frame(12'd0, 12'd0, 1'b0);
		settle();

		// image size below range: centre drops to zero
		write_regs(16'd0, 16'd1, KP_RESET, KD_RESET);
		send_frame(12'd0, 12'd0, 1'b0);
		send_frame(12'd4095, 12'd4095, 1'b0);
		send_frame(12'd2048, 12'd1, 1'b0);
		settle();

		// random phases over several register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					w = WIDTH_RESET; h = HEIGHT_RESET; gp = KP_RESET; gd = KD_RESET;
				end
				1: begin
					w = 16'd4095; h = 16'd4095; gp = 16'hFFFF; gd = 16'hFFFF;
				end
				2: begin
					w = 16'd2; h = 16'd2; gp = 16'd0; gd = 16'd0;
				end
				default: begin
					w  = 16'($urandom_range(0, 65535));
					h  = 16'($urandom_range(0, 65535));
					gp = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 4000));
					gd = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 4000));
				end
			endcase
			write_regs(w, h, gp, gd);
			burst   = (p % 3 == 1);
			tracked = 0;
			while (tracked < PHASE_FRAMES) begin
				lost = ($urandom_range(0, 7) == 0);
				send_frame(pick_pos(cur_w), pick_pos(cur_h), lost);
				if (!lost)
					tracked++;
			end
			burst = 1'b0;
			settle();
		end

		wait (duties_due == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && duties_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_datapath.sv
hw/rtl/pan_tilt_pd_servo_tracker.sv
hw/rtl/ptt_checker.sv
tb/tracker_checker.sv
tb/testbench.sv
